@@ sv/swag_pkg.sv @@
`timescale 1ns / 1ps
package swag_pkg;
	localparam int TRACKER_DEPTH = 4096;
	localparam int STAMPS_PER_SOURCE = 8;
	localparam int SLOT_W = $clog2(TRACKER_DEPTH);
	localparam int PTR_W = (STAMPS_PER_SOURCE > 1) ? $clog2(STAMPS_PER_SOURCE) : 1;
	localparam int FILL_W = $clog2(STAMPS_PER_SOURCE + 1);
	localparam int USED_W = $clog2(TRACKER_DEPTH + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONCURRENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_WINDOW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SOURCES = 2'd3;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_CONC_FULL = 3'd1,
		ST_TRK_FULL  = 3'd2,
		ST_OVER      = 3'd3,
		ST_RELEASED  = 3'd4,
		ST_REL_IGN   = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]  max_concurrent;
		logic [15:0] window_seconds;
		logic [3:0]  max_per_window;
		logic [12:0] max_sources;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] source_key;
		logic [31:0] now_sec;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] active_now;
		logic [3:0] source_count;
	} rsp_t;
endpackage

@@ sv/swag_if.sv @@
`timescale 1ns / 1ps
interface swag_req_if import swag_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface swag_rsp_if import swag_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/swag_cfg.sv @@
`timescale 1ns / 1ps
module swag_cfg import swag_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);
	cfg_t cfg_q;

	// write the register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_concurrent <= 8'd32;
			cfg_q.window_seconds <= 16'd10;
			cfg_q.max_per_window <= 4'd8;
			cfg_q.max_sources <= 13'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_CONCURRENT: cfg_q.max_concurrent <= cfg_data[7:0];
				CFG_WINDOW_SECONDS: cfg_q.window_seconds <= cfg_data[15:0];
				CFG_MAX_PER_WINDOW: cfg_q.max_per_window <= cfg_data[3:0];
				CFG_MAX_SOURCES: cfg_q.max_sources <= cfg_data[12:0];
				default: ;
			endcase
		end
	end
	assign cfg = cfg_q;
endmodule

@@ sv/swag_engine.sv @@
`timescale 1ns / 1ps
module swag_engine import swag_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	swag_req_if.sink  req,
	swag_rsp_if.source rsp
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOOK, S_LOOK_CHK, S_SWP_RD, S_SWP_CHK, S_FREE_RD,
		S_FREE_CHK, S_ENT_RD, S_ENT_CHK
	} state_t;

	localparam int STAMP_DEPTH = TRACKER_DEPTH * STAMPS_PER_SOURCE;
	localparam int SW = SLOT_W + PTR_W;

	// per-entry memories
	logic [31:0]       key_mem [TRACKER_DEPTH];
	logic [PTR_W-1:0]  head_mem [TRACKER_DEPTH];
	logic [FILL_W-1:0] fill_mem [TRACKER_DEPTH];
	logic              vld_mem [TRACKER_DEPTH];
	logic [31:0]       stamp_mem [STAMP_DEPTH];

	state_t            state_q;
	logic [SLOT_W:0]   idx_q;
	logic [SLOT_W-1:0] slot_q;
	logic [USED_W-1:0] used_q;
	logic [7:0]        active_q;
	req_t              req_q;
	rsp_t              rsp_q;
	logic              rsp_vld_q;
	logic              sweep_q;

	// registered read data
	logic [31:0]       key_rd_q;
	logic [PTR_W-1:0]  head_rd_q;
	logic [FILL_W-1:0] fill_rd_q;
	logic              vld_rd_q;
	logic [31:0]       stamp_rd_q;

	// working copy of the entry being trimmed
	logic [PTR_W-1:0]  head_q;
	logic [FILL_W-1:0] fill_q;

	// memory port controls
	logic              meta_we;
	logic [SLOT_W-1:0] meta_wa;
	logic              meta_vld_d;
	logic [31:0]       meta_key_d;
	logic              key_we;
	logic [PTR_W-1:0]  meta_head_d;
	logic [FILL_W-1:0] meta_fill_d;
	logic [SLOT_W-1:0] meta_ra;
	logic              stamp_we;
	logic [SW-1:0]     stamp_wa;
	logic [SW-1:0]     stamp_ra;

	logic [FILL_W-1:0] lim_win;
	logic [USED_W-1:0] lim_tab;
	logic [31:0]       age;
	logic              expired;
	logic [PTR_W-1:0]  head_nx;
	logic [PTR_W-1:0]  wr_pos;
	logic              last_idx;

	function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W:0] v);
		logic [PTR_W:0] s;
		s = v;
		if (s >= (PTR_W+1)'(STAMPS_PER_SOURCE))
			s = s - (PTR_W+1)'(STAMPS_PER_SOURCE);
		return s[PTR_W-1:0];
	endfunction

	assign lim_win = (32'(cfg.max_per_window) > 32'(STAMPS_PER_SOURCE)) ?
		FILL_W'(STAMPS_PER_SOURCE) : FILL_W'(cfg.max_per_window);
	assign lim_tab = (32'(cfg.max_sources) > 32'(TRACKER_DEPTH)) ?
		USED_W'(TRACKER_DEPTH) : USED_W'(cfg.max_sources);
	assign age = req_q.now_sec - stamp_rd_q;
	assign expired = (age >= {16'd0, cfg.window_seconds});
	assign head_nx = wrap_ptr({1'b0, head_q} + (PTR_W+1)'(1));
	assign wr_pos = wrap_ptr({1'b0, head_q} + (PTR_W+1)'(fill_q));
	assign last_idx = (idx_q[SLOT_W-1:0] == SLOT_W'(TRACKER_DEPTH - 1));

	assign req.ready = (state_q == S_IDLE) && !rsp_vld_q;
	assign rsp.valid = rsp_vld_q;
	assign rsp.data = rsp_q;

	// memory writes and registered reads
	always_ff @(posedge clk) begin
		if (meta_we) begin
			vld_mem[meta_wa] <= meta_vld_d;
			head_mem[meta_wa] <= meta_head_d;
			fill_mem[meta_wa] <= meta_fill_d;
		end
		if (key_we)
			key_mem[meta_wa] <= meta_key_d;
		if (stamp_we)
			stamp_mem[stamp_wa] <= req_q.now_sec;
		key_rd_q <= key_mem[meta_ra];
		head_rd_q <= head_mem[meta_ra];
		fill_rd_q <= fill_mem[meta_ra];
		vld_rd_q <= vld_mem[meta_ra];
		stamp_rd_q <= stamp_mem[stamp_ra];
	end

	// drive memory ports from the sequencer
	always_comb begin
		meta_we = 1'b0;
		key_we = 1'b0;
		meta_wa = slot_q;
		meta_vld_d = 1'b1;
		meta_key_d = req_q.source_key;
		meta_head_d = head_q;
		meta_fill_d = fill_q;
		meta_ra = idx_q[SLOT_W-1:0];
		stamp_we = 1'b0;
		stamp_wa = {slot_q, wr_pos};
		stamp_ra = {slot_q, head_q};
		unique case (state_q)
			S_CLEAR: begin
				meta_we = 1'b1;
				meta_wa = idx_q[SLOT_W-1:0];
				meta_vld_d = 1'b0;
				meta_head_d = '0;
				meta_fill_d = '0;
			end
			S_SWP_CHK, S_ENT_CHK: begin
				if (!(fill_q != '0 && expired)) begin
					meta_we = 1'b1;
					meta_vld_d = (state_q == S_ENT_CHK) || (fill_q != '0);
				end
				if (fill_q != '0 && expired)
					stamp_ra = {slot_q, head_nx};
				if (state_q == S_ENT_CHK && !(fill_q != '0 && expired) &&
				    fill_q < lim_win) begin
					stamp_we = 1'b1;
					meta_fill_d = fill_q + FILL_W'(1);
				end
			end
			S_FREE_CHK: begin
				if (!vld_rd_q) begin
					meta_we = 1'b1;
					key_we = 1'b1;
					meta_wa = idx_q[SLOT_W-1:0];
					meta_head_d = '0;
					meta_fill_d = '0;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			slot_q <= '0;
			used_q <= '0;
			active_q <= '0;
			rsp_vld_q <= 1'b0;
			sweep_q <= 1'b0;
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready)
				rsp_vld_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					// clear valid, head and fill one entry a cycle
					idx_q <= idx_q + 1'b1;
					if (last_idx)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						idx_q <= '0;
						if (req.data.kind) begin
							rsp_q.source_count <= '0;
							if (active_q == '0) begin
								rsp_q.status <= ST_REL_IGN;
								rsp_q.active_now <= active_q;
							end else begin
								rsp_q.status <= ST_RELEASED;
								rsp_q.active_now <= active_q - 8'd1;
								active_q <= active_q - 8'd1;
							end
							rsp_vld_q <= 1'b1;
						end else if (active_q >= cfg.max_concurrent) begin
							rsp_q <= '{ST_CONC_FULL, active_q, 4'd0};
							rsp_vld_q <= 1'b1;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					// read address idx_q presented this cycle
					state_q <= S_LOOK_CHK;
				end
				S_LOOK_CHK: begin
					if (vld_rd_q && key_rd_q == req_q.source_key) begin
						slot_q <= idx_q[SLOT_W-1:0];
						head_q <= head_rd_q;
						fill_q <= fill_rd_q;
						state_q <= S_ENT_RD;
					end else if (last_idx) begin
						idx_q <= '0;
						if (used_q >= lim_tab) begin
							sweep_q <= 1'b1;
							state_q <= S_SWP_RD;
						end else begin
							state_q <= S_FREE_RD;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_LOOK;
					end
				end
				S_SWP_RD: begin
					// when sweep_q is set, wait for the registered meta data of entry idx_q
					if (sweep_q) begin
						sweep_q <= 1'b0;
					end else if (!vld_rd_q) begin
						if (last_idx) begin
							idx_q <= '0;
							if (used_q >= lim_tab) begin
								rsp_q <= '{ST_TRK_FULL, active_q, 4'd0};
								rsp_vld_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_FREE_RD;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
							sweep_q <= 1'b1;
						end
					end else begin
						slot_q <= idx_q[SLOT_W-1:0];
						head_q <= head_rd_q;
						fill_q <= fill_rd_q;
						state_q <= S_ENT_RD;
						idx_q[SLOT_W] <= 1'b1;
					end
				end
				S_ENT_RD: begin
					// stamp at head is read this cycle
					state_q <= idx_q[SLOT_W] ? S_SWP_CHK : S_ENT_CHK;
				end
				S_SWP_CHK: begin
					if (fill_q != '0 && expired) begin
						head_q <= head_nx;
						fill_q <= fill_q - FILL_W'(1);
						state_q <= S_ENT_RD;
					end else begin
						if (fill_q == '0 && used_q != '0)
							used_q <= used_q - 1'b1;
						if (last_idx) begin
							idx_q <= '0;
							if (fill_q == '0 && used_q != '0 &&
							    (used_q - 1'b1) < lim_tab)
								state_q <= S_FREE_RD;
							else if (used_q >= lim_tab) begin
								rsp_q <= '{ST_TRK_FULL, active_q, 4'd0};
								rsp_vld_q <= 1'b1;
								state_q <= S_IDLE;
							end else
								state_q <= S_FREE_RD;
						end else begin
							idx_q <= {1'b0, idx_q[SLOT_W-1:0] + 1'b1};
							sweep_q <= 1'b1;
							state_q <= S_SWP_RD;
						end
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					// take the lowest free slot as a fresh entry
					if (!vld_rd_q) begin
						slot_q <= idx_q[SLOT_W-1:0];
						head_q <= '0;
						fill_q <= '0;
						used_q <= used_q + 1'b1;
						state_q <= S_ENT_RD;
					end else if (last_idx) begin
						rsp_q <= '{ST_TRK_FULL, active_q, 4'd0};
						rsp_vld_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_FREE_RD;
					end
				end
				S_ENT_CHK: begin
					if (fill_q != '0 && expired) begin
						head_q <= head_nx;
						fill_q <= fill_q - FILL_W'(1);
						state_q <= S_ENT_RD;
					end else begin
						if (fill_q < lim_win) begin
							active_q <= active_q + 8'd1;
							rsp_q <= '{ST_GRANTED, active_q + 8'd1,
								4'(fill_q + FILL_W'(1))};
						end else begin
							rsp_q <= '{ST_OVER, active_q, 4'(fill_q)};
						end
						rsp_vld_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result is never raised from the clearing state
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q) != S_CLEAR)
		else $error("result raised during clearing");
	// no new word while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q |-> !req.ready)
		else $error("accept while result pending");
	// entry count never exceeds the depth
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TRACKER_DEPTH))
		else $error("entry count overflow");
endmodule

@@ sv/sliding_window_admission_gate_top.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// req       in   valid/ready    kind, source_key, now_sec
// rsp       out  valid/ready    status, active_now, source_count
// cfg       in   cfg_we         cfg_index, cfg_data
//
// Release and concurrency-full words are answered straight from idle. An acquire
// looks the key up entry by entry (every entry on a miss), then trims expired
// timestamps one at a time and logs the new one if under the limit. A new key
// adds a search for the lowest free slot; at a full table a sweep first visits
// every entry, trimming the stamps of each valid one and freeing those left empty.
// A clearing pass over every entry follows reset; a waiting result blocks.
module sliding_window_admission_gate_top import swag_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	swag_req_if.sink              req,
	swag_rsp_if.source            rsp
);
	cfg_t cfg;

	swag_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
	);

	swag_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp)
	);
endmodule
